// File: sv/icof_pkg.sv
`timescale 1ns / 1ps

package icof_pkg;

   // map geometry
   localparam int POSITIONS  = 1048576;
   localparam int WORD_BITS  = 64;
   localparam int WORD_BYTES = WORD_BITS / 8;
   localparam int BIT_SEL_W  = $clog2(WORD_BITS);
   localparam int MAP_WORDS  = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = $clog2(MAP_WORDS);

   // field widths
   localparam int ACT_W      = 2;
   localparam int POS_W      = 21;
   localparam int MODE_W     = 2;
   localparam int PCT_W      = 7;
   localparam int CNT_W      = $clog2(WORD_BITS + 1);
   localparam int PROD_W     = POS_W + PCT_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POSITIONS);
   localparam logic [POS_W-1:0] ACC_MAX   = {POS_W{1'b1}};
   localparam logic [PCT_W-1:0] PCT_SCALE = PCT_W'(100);

   // action codes
   localparam logic [ACT_W-1:0] ACT_MARK  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_QUERY = 2'd1;
   localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

   // filter modes
   localparam logic [MODE_W-1:0] MODE_ANY  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NONE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MORE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_LESS = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MORE_PERCENT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LESS_PERCENT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT_MAP   = 2'd3;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [POS_W-1:0] range_start;
      logic [POS_W-1:0] range_end;
      logic             last_block;
   } req_word_type;

   typedef struct packed {
      logic             keep;
      logic [POS_W-1:0] overlap_count;
      logic [POS_W-1:0] total_length;
      logic             out_of_range;
   } rsp_word_type;

   // population count, byte groups summed
   function automatic logic [CNT_W-1:0] ones_count(input logic [WORD_BITS-1:0] v);
      logic [CNT_W-1:0] total;
      logic [3:0]       part;
      total = '0;
      for (int g = 0; g < WORD_BYTES; g++) begin
         part = '0;
         for (int b = 0; b < 8; b++) begin
            part = part + 4'(v[g*8+b]);
         end
         total = total + CNT_W'(part);
      end
      return total;
   endfunction

endpackage

// File: sv/interval_coverage_overlap_filter.sv
`timescale 1ns / 1ps

// a query or mark block is accepted, walks the map words it touches, then waits in ST_DRAIN
//   (one word read per cycle, read-modify-write or count pipeline drains before the next word in)
// a last query block then passes the products and compare steps before the result word is loaded
// a clear word sweeps the whole map of 16384 words, one word a cycle; one word in flight at a time
// reset: synchronous, active high; registers return to defaults, then a clearing pass over
//   all 16384 words zeroes the map with req_ready low (csr writes still taken)

module interval_coverage_overlap_filter
   import icof_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_DRAIN,
      ST_MULT,
      ST_DECIDE
   } state_type;

   // coverage map, one read and one write port
   logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // sequencer
   state_type            state_ff, state_in;
   logic [ADDR_W-1:0]    cur_ff, cur_in;      // word being read, also sweep counter
   logic [ADDR_W-1:0]    end_ff, end_in;
   logic [BIT_SEL_W-1:0] lo_ff, lo_in;
   logic [BIT_SEL_W-1:0] hi_ff, hi_in;
   logic                 first_ff, first_in;
   logic                 mark_ff, mark_in;
   logic                 lastblk_ff, lastblk_in;

   // read stage and count stage
   logic                 s1_vld_ff, s1_vld_in;
   logic                 s1_mark_ff;
   logic [ADDR_W-1:0]    s1_addr_ff;
   logic [WORD_BITS-1:0] s1_mask_ff, s1_mask_in;
   logic                 pc_vld_ff, pc_vld_in;
   logic [CNT_W-1:0]     pc_ff, pc_in;

   // interval accumulators
   logic [POS_W-1:0]     ovl_acc_ff, ovl_acc_in;
   logic [POS_W-1:0]     len_acc_ff, len_acc_in;
   logic                 err_ff, err_in;
   logic [PROD_W-1:0]    prod_cnt_ff, prod_cnt_in;
   logic [PROD_W-1:0]    prod_pct_ff, prod_pct_in;

   // configuration
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [PCT_W-1:0]     more_ff, more_in;
   logic [PCT_W-1:0]     less_ff, less_in;
   logic                 inv_ff, inv_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 rsp_load;

   // decoded request
   logic                 accept;
   logic [POS_W-1:0]     rs, re, s_w, e_w, e_c, e_last, len_add;
   logic                 zero_size, span_empty, query_bad;
   logic                 at_end;
   logic [WORD_BITS-1:0] lo_mask, hi_mask, rd_eff;
   logic [POS_W-1:0]     len_eff;
   logic [PCT_W-1:0]     pct_sel;
   logic                 keep_raw;

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[POS_W] ? ACC_MAX : sum[POS_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // range widening for zero-size items, then clip to the map
   always_comb begin
      rs         = req_data.range_start;
      re         = req_data.range_end;
      zero_size  = (rs == re);
      s_w        = (zero_size && rs != '0) ? rs - POS_W'(1) : rs;
      e_w        = (zero_size && re < POS_LIMIT) ? re + POS_W'(1) : re;
      e_c        = (e_w > POS_LIMIT) ? POS_LIMIT : e_w;
      e_last     = e_c - POS_W'(1);
      span_empty = (e_c <= s_w);
      query_bad  = (re > POS_LIMIT) || (rs > re);
      len_add    = zero_size ? POS_W'(2) : re - rs;
   end

   // mask of the word now being read
   always_comb begin
      at_end  = (cur_ff == end_ff);
      lo_mask = first_ff ? ({WORD_BITS{1'b1}} << lo_ff) : {WORD_BITS{1'b1}};
      hi_mask = at_end ? ({WORD_BITS{1'b1}} >> (BIT_SEL_W'(WORD_BITS - 1) - hi_ff))
                       : {WORD_BITS{1'b1}};
   end

   // map write: clearing sweep or mark write-back in the cycle after the read
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = s1_addr_ff;
      mem_wdata = rdata_ff | s1_mask_ff;
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = cur_ff;
         mem_wdata = '0;
      end else if (s1_vld_ff && s1_mark_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= map_mem[cur_ff];
   end

   // count stage, inverted reading if configured
   always_comb begin
      rd_eff      = inv_ff ? ~rdata_ff : rdata_ff;
      pc_in       = ones_count(rd_eff & s1_mask_ff);
      pc_vld_in   = s1_vld_ff && !s1_mark_ff;
      s1_vld_in   = (state_ff == ST_WALK);
      s1_mask_in  = lo_mask & hi_mask;
   end

   // filter decision inputs
   always_comb begin
      len_eff     = (len_acc_ff == '0) ? POS_W'(2) : len_acc_ff;
      pct_sel     = (mode_ff == MODE_MORE) ? more_ff : less_ff;
      prod_cnt_in = PROD_W'(ovl_acc_ff) * PROD_W'(PCT_SCALE);
      prod_pct_in = PROD_W'(pct_sel) * PROD_W'(len_eff);
      case (mode_ff)
         MODE_ANY:  keep_raw = (ovl_acc_ff != '0);
         MODE_NONE: keep_raw = (ovl_acc_ff == '0);
         MODE_MORE: keep_raw = (prod_cnt_ff >= prod_pct_ff);
         MODE_LESS: keep_raw = (prod_cnt_ff <= prod_pct_ff);
         default:   keep_raw = 1'b0;
      endcase
   end

   // sequencer and accumulators
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      end_in       = end_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      first_in     = first_ff;
      mark_in      = mark_ff;
      lastblk_in   = lastblk_ff;
      ovl_acc_in   = ovl_acc_ff;
      len_acc_in   = len_acc_ff;
      err_in       = err_ff;
      rsp_load     = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (pc_vld_ff) begin
         ovl_acc_in = sat_add(ovl_acc_ff, POS_W'(pc_ff));
      end

      case (state_ff)
         ST_CLEAR: begin
            cur_in = cur_ff + ADDR_W'(1);
            if (cur_ff == {ADDR_W{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cur_in     = s_w[BIT_SEL_W +: ADDR_W];
               end_in     = e_last[BIT_SEL_W +: ADDR_W];
               lo_in      = s_w[BIT_SEL_W-1:0];
               hi_in      = e_last[BIT_SEL_W-1:0];
               first_in   = 1'b1;
               lastblk_in = req_data.last_block;
               case (req_data.action)
                  ACT_MARK: begin
                     mark_in = 1'b1;
                     if (!span_empty) begin
                        state_in = ST_WALK;
                     end
                  end
                  ACT_QUERY: begin
                     mark_in = 1'b0;
                     if (query_bad) begin
                        err_in = 1'b1;
                        if (req_data.last_block) begin
                           state_in = ST_MULT;
                        end
                     end else begin
                        len_acc_in = sat_add(len_acc_ff, len_add);
                        state_in   = ST_WALK;
                     end
                  end
                  ACT_CLEAR: begin
                     cur_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            first_in = 1'b0;
            cur_in   = cur_ff + ADDR_W'(1);
            if (at_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !pc_vld_ff) begin
               state_in = (!mark_ff && lastblk_ff) ? ST_MULT : ST_IDLE;
            end
         end
         ST_MULT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load                 = 1'b1;
               rsp_valid_in             = 1'b1;
               rsp_in.keep              = keep_raw && !err_ff;
               rsp_in.overlap_count     = ovl_acc_ff;
               rsp_in.total_length      = len_acc_ff;
               rsp_in.out_of_range      = err_ff;
               ovl_acc_in               = '0;
               len_acc_in               = '0;
               err_in                   = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration writes
   always_comb begin
      mode_in = mode_ff;
      more_in = more_ff;
      less_in = less_ff;
      inv_in  = inv_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_MODE:  mode_in = csr_wdata[MODE_W-1:0];
            CSR_MORE_PERCENT: more_in = csr_wdata[PCT_W-1:0];
            CSR_LESS_PERCENT: less_in = csr_wdata[PCT_W-1:0];
            CSR_INVERT_MAP:   inv_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         pc_vld_ff    <= 1'b0;
         ovl_acc_ff   <= '0;
         len_acc_ff   <= '0;
         err_ff       <= 1'b0;
         mode_ff      <= MODE_ANY;
         more_ff      <= '0;
         less_ff      <= PCT_SCALE;
         inv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         s1_vld_ff    <= s1_vld_in;
         pc_vld_ff    <= pc_vld_in;
         ovl_acc_ff   <= ovl_acc_in;
         len_acc_ff   <= len_acc_in;
         err_ff       <= err_in;
         mode_ff      <= mode_in;
         more_ff      <= more_in;
         less_ff      <= less_in;
         inv_ff       <= inv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      end_ff      <= end_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      first_ff    <= first_in;
      mark_ff     <= mark_in;
      lastblk_ff  <= lastblk_in;
      s1_mark_ff  <= mark_ff;
      s1_addr_ff  <= cur_ff;
      s1_mask_ff  <= s1_mask_in;
      pc_ff       <= pc_in;
      prod_cnt_ff <= prod_cnt_in;
      prod_pct_ff <= prod_pct_in;
      rsp_ff      <= rsp_in;
   end

`ifndef SYNTH
   // no word may still be in flight when a new item can enter
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!s1_vld_ff && !pc_vld_ff))
      else $error("map pipeline busy while accepting words");

   // counted positions never exceed summed length
   a_count_le_length: assert property (@(posedge clock) disable iff (reset)
      ovl_acc_ff <= len_acc_ff)
      else $error("overlap count above total length");

   // interval state starts fresh once its result is loaded
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (ovl_acc_ff == '0 && len_acc_ff == '0 && !err_ff))
      else $error("accumulators not cleared after result");
`endif

endmodule
